/* hw/rtl/lpfx_pkg.sv */
// Package for the length-prefixed frame XOR checker.
// Holds the frame layout constants, the pair decoder and the result type.
// Depends on nothing; every other file uses it by scoped names.
package lpfx_pkg;

	localparam int unsigned CharW     = 8;
	localparam int unsigned PosW      = 10;
	localparam int unsigned CapCount  = 6;
	localparam int unsigned CapIdxW   = 3;

	localparam logic [CharW-1:0]   AsciiZero    = 8'd48;
	localparam logic [PosW-1:0]    PosLenHi     = 10'd2;
	localparam logic [PosW-1:0]    PosLenLo     = 10'd3;
	localparam logic [PosW-1:0]    PosFirstBody = 10'd4;
	localparam logic [PosW-1:0]    PosCapEnd    = 10'd10;

	typedef logic [CharW-1:0] char_t;
	typedef logic [PosW-1:0]  pos_t;

	typedef struct packed {
		logic  last;
		logic  checksum_ok;
		char_t device_type;
		char_t device_number;
		char_t port_number;
	} result_t;

	// ((hi - '0') * 16 + (lo - '0')) mod 256. The high term reduces to hi * 16
	// because 48 * 16 is a multiple of 256.
	function automatic char_t decode_pair(input char_t hi, input char_t lo);
		char_t hi_sh;
		hi_sh = {hi[3:0], 4'b0000};
		return char_t'(hi_sh + lo - AsciiZero);
	endfunction

endpackage

/* hw/rtl/length_prefixed_frame_xor_check_top.sv */
// Top level of the length-prefixed frame XOR checker.
// Holds the input word register and the result register around lpfx_frame.
// Depends on lpfx_pkg and lpfx_frame.
//
// Usage:
// The input channel (in_valid, in_stall, rx_char) carries one received
// character per word. A frame is two header characters, two length
// characters, 2*L body characters and two checksum characters.
// The output channel (out_valid, out_stall and the four result fields)
// carries one word per frame: the checksum verdict and the three decoded
// pairs at frame positions 4 to 9.
// One character is taken every cycle while in_stall is low. A character is
// held in the input register and is then processed into the result register,
// from which the result word is offered on the output channel.
// When the result register holds a word and the receiver stalls, both the
// input register and the frame state hold and in_stall is raised until
// the word is taken.
// Reset clears the frame state, so the first character after reset is the
// first header character of a frame; no result is pending after reset.
module length_prefixed_frame_xor_check_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       checksum_ok,
	output logic [7:0] device_type,
	output logic [7:0] device_number,
	output logic [7:0] port_number
);

	logic              adv;
	logic              valid_s1;
	lpfx_pkg::char_t   rx_char_s1;
	logic              step;
	lpfx_pkg::result_t res;
	lpfx_pkg::pos_t    pos;
	logic              out_valid_q;
	lpfx_pkg::result_t out_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			rx_char_s1 <= rx_char;
		end
	end

	lpfx_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (rx_char_s1),
		.result  (res),
		.pos     (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res.last;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.last) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign checksum_ok   = out_q.checksum_ok;
	assign device_type   = out_q.device_type;
	assign device_number = out_q.device_number;
	assign port_number   = out_q.port_number;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos <= 10'd515)
		else $error("frame position beyond the longest frame");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.last |=> out_valid)
		else $error("frame end did not produce a result word");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.last |=> pos == '0)
		else $error("frame state not cleared after the last character");

	a_hold_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos))
		else $error("frame state moved while the result was stalled");

endmodule

/* hw/rtl/lpfx_frame.sv */
// Frame tracker: position counter, length, running XOR and captured characters.
// Computes the frame result for the character it is stepped with.
// Depends on lpfx_pkg.
module lpfx_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lpfx_pkg::char_t   char_in,
	output lpfx_pkg::result_t result,
	output lpfx_pkg::pos_t    pos
);

	lpfx_pkg::pos_t  pos_q;
	lpfx_pkg::char_t len_first_q;
	lpfx_pkg::char_t body_len_q;
	lpfx_pkg::char_t xor_q;
	lpfx_pkg::char_t chk_first_q;
	lpfx_pkg::char_t cap_q [lpfx_pkg::CapCount];
	lpfx_pkg::char_t cap_eff [lpfx_pkg::CapCount];

	lpfx_pkg::pos_t  body_end;
	lpfx_pkg::pos_t  frame_end;
	logic            in_body;
	logic            in_cap;
	logic            last;
	logic [lpfx_pkg::CapIdxW-1:0] cap_idx;
	lpfx_pkg::char_t chk;

	assign body_end  = lpfx_pkg::PosFirstBody + {1'b0, body_len_q, 1'b0};
	assign frame_end = body_end + 10'd1;
	assign in_body   = pos_q >= lpfx_pkg::PosFirstBody;
	assign last      = in_body && (pos_q >= frame_end);
	assign in_cap    = in_body && (pos_q < lpfx_pkg::PosCapEnd);
	assign cap_idx   = lpfx_pkg::CapIdxW'(pos_q - lpfx_pkg::PosFirstBody);

	always_comb begin
		for (int i = 0; i < lpfx_pkg::CapCount; i++) begin
			cap_eff[i] = (in_cap && (cap_idx == lpfx_pkg::CapIdxW'(i))) ? char_in : cap_q[i];
		end
	end

	assign chk = lpfx_pkg::decode_pair(chk_first_q, char_in);

	always_comb begin
		result.last          = last;
		result.checksum_ok   = (xor_q == chk);
		result.device_type   = lpfx_pkg::decode_pair(cap_eff[0], cap_eff[1]);
		result.device_number = lpfx_pkg::decode_pair(cap_eff[2], cap_eff[3]);
		result.port_number   = lpfx_pkg::decode_pair(cap_eff[4], cap_eff[5]);
	end

	assign pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			len_first_q <= '0;
			body_len_q  <= '0;
			xor_q       <= '0;
			chk_first_q <= '0;
			for (int i = 0; i < lpfx_pkg::CapCount; i++) begin
				cap_q[i] <= '0;
			end
		end else if (step) begin
			priority if (pos_q < lpfx_pkg::PosLenHi) begin
				pos_q <= pos_q + 10'd1;
			end else if (pos_q == lpfx_pkg::PosLenHi) begin
				len_first_q <= char_in;
				pos_q       <= pos_q + 10'd1;
			end else if (pos_q == lpfx_pkg::PosLenLo) begin
				body_len_q <= lpfx_pkg::decode_pair(len_first_q, char_in);
				pos_q      <= pos_q + 10'd1;
			end else if (last) begin
				pos_q       <= '0;
				len_first_q <= '0;
				body_len_q  <= '0;
				xor_q       <= '0;
				chk_first_q <= '0;
				for (int i = 0; i < lpfx_pkg::CapCount; i++) begin
					cap_q[i] <= '0;
				end
			end else begin
				if (in_cap) begin
					cap_q[cap_idx] <= char_in;
				end
				if (pos_q < body_end) begin
					xor_q <= xor_q ^ char_in;
				end else begin
					chk_first_q <= char_in;
				end
				pos_q <= pos_q + 10'd1;
			end
		end
	end

endmodule
